FILE: hdl/pidc_pkg.sv
// Shared widths, constants, register indexes and command/status types for
// the PID controller step block. Used by every module under hdl.
package pidc_pkg;

    localparam int DATA_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int ERR_W      = DATA_W + 1;
    localparam int PROD_W     = ERR_W + DATA_W;
    localparam int INC_W      = PROD_W + DATA_W + 1;
    localparam int ACC_W      = 48;
    localparam int ACC_SUM_W  = INC_W + 1;
    localparam int MS_W       = 10;
    localparam int DK_W       = PROD_W + MS_W;
    localparam int I_W        = 39;
    localparam int SUM_W      = 46;
    localparam int DIV_W      = 48;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    // integral / 1000 as (magnitude / 8) * ceil(2^52 / 125) >> 52,
    // built from four 23 x 23 partial products
    localparam int RQ_X_W     = DIV_W - 3;
    localparam int RQ_HALF_W  = 23;
    localparam int RQ_M_W     = 46;
    localparam int RQ_SHIFT   = 52;
    localparam int RQ_ACC_W   = RQ_SHIFT + I_W;
    localparam int RQ_STEPS   = 4;
    localparam int RQ_CNT_W   = 3;
    localparam logic [RQ_M_W-1:0] RECIP_125 = 46'd36028797018964;

    // milliseconds per second, scale of the integral and derivative terms
    localparam logic [DATA_W-1:0] MS_PER_S = 16'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_LIMIT    = 3'd4
    } pidc_reg_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic acc;
        logic div_load;
        logic sign;
        logic sum;
        logic out_load;
    } pidc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
    } pidc_stat_t;

endpackage

FILE: hdl/pidc_div.sv
// Unsigned sequential divider, restoring, two quotient bits per cycle.
// Depends on pidc_pkg for widths and step count.
module pidc_div
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              busy
);

    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [DATA_W:0]   trial1;
    logic [DATA_W:0]   trial2;
    logic              ge1;
    logic              ge2;
    logic [DATA_W-1:0] rem1;
    logic [DATA_W-1:0] rem_next;
    logic [DIV_W-1:0]  quo_next;

    // two restoring steps: shift in a dividend bit, subtract when it fits
    always_comb
    begin
        trial1   = {rem_reg, quo_reg[DIV_W-1]};
        ge1      = (trial1 >= {1'b0, divisor});
        rem1     = ge1 ? DATA_W'(trial1 - {1'b0, divisor}) : trial1[DATA_W-1:0];
        trial2   = {rem1, quo_reg[DIV_W-2]};
        ge2      = (trial2 >= {1'b0, divisor});
        rem_next = ge2 ? DATA_W'(trial2 - {1'b0, divisor}) : trial2[DATA_W-1:0];
        quo_next = {quo_reg[DIV_W-3:0], ge1, ge2};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

endmodule

FILE: hdl/pidc_datapath.sv
// Datapath of the PID step: configuration registers, multipliers, integral
// accumulator, reciprocal unit, divider and the output clamp. Uses pidc_pkg, pidc_div.
module pidc_datapath
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic signed [DATA_W-1:0] measurement,
    input  logic [DATA_W-1:0]        elapsed_ms,
    input  pidc_cmd_t                cmd,
    output pidc_stat_t               stat,
    output logic signed [DATA_W-1:0] drive,
    output logic                     clamped
);

    // configuration
    logic signed [DATA_W-1:0] setpoint_reg;
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    // controller state
    logic signed [ACC_W-1:0]  integral_reg;
    logic signed [DATA_W-1:0] prev_reg;

    // working registers
    logic signed [DATA_W-1:0] meas_reg;
    logic [DATA_W-1:0]        dt_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] ei_reg;
    logic signed [PROD_W-1:0] dg_reg;
    logic signed [INC_W-1:0]  inc_reg;
    logic signed [DK_W-1:0]   dk_reg;
    logic                     int_neg_reg;
    logic                     dk_neg_reg;
    logic signed [I_W-1:0]    i_reg;
    logic signed [DK_W-1:0]   d_reg;
    logic signed [SUM_W-1:0]  s_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     clamped_reg;

    // reciprocal unit for integral / 1000
    logic [RQ_CNT_W-1:0]      rq_cnt_reg;
    logic [RQ_X_W-1:0]        rq_x_reg;
    logic [RQ_ACC_W-1:0]      rq_acc_reg;

    logic signed [ERR_W-1:0]     err;
    logic signed [ERR_W-1:0]     diff;
    logic signed [ACC_SUM_W-1:0] acc_sum;
    logic signed [ACC_W-1:0]     integral_next;
    logic [DIV_W-1:0]            int_mag;
    logic [DK_W-1:0]             dk_mag;
    logic [I_W-1:0]              q_int;
    logic [DIV_W-1:0]            q_dk;
    logic                        busy_rq;
    logic                        busy_dk;
    logic                        rq_a_hi;
    logic                        rq_b_hi;
    logic [RQ_HALF_W-1:0]        rq_a;
    logic [RQ_HALF_W-1:0]        rq_b;
    logic [2*RQ_HALF_W-1:0]      rq_pp;
    logic [RQ_ACC_W-1:0]         rq_term;
    logic signed [SUM_W-1:0]     lim;
    logic signed [SUM_W-1:0]     s_adj;
    logic signed [DATA_W-1:0]    limit_s;
    logic                        over;
    logic                        under;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (pidc_reg_t'(cfg_index))
                REG_SETPOINT: setpoint_reg <= cfg_data;
                REG_GAIN_P:   gain_p_reg   <= cfg_data;
                REG_GAIN_I:   gain_i_reg   <= cfg_data;
                REG_GAIN_D:   gain_d_reg   <= cfg_data;
                REG_LIMIT:    limit_reg    <= cfg_data[LIMIT_W-1:0];
                default:      ;
            endcase
        end
    end

    // error and measurement change
    assign err  = ERR_W'(setpoint_reg) - ERR_W'(meas_reg);
    assign diff = ERR_W'(meas_reg) - ERR_W'(prev_reg);

    // saturating accumulate
    assign acc_sum = ACC_SUM_W'(integral_reg) + ACC_SUM_W'(inc_reg);
    always_comb
    begin
        if (acc_sum > ACC_SUM_W'(ACC_MAX))
        begin
            integral_next = ACC_MAX;
        end
        else if (acc_sum < ACC_SUM_W'(ACC_MIN))
        begin
            integral_next = ACC_MIN;
        end
        else
        begin
            integral_next = acc_sum[ACC_W-1:0];
        end
    end

    // state: integral and previous measurement
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            if (cmd.mul1)
            begin
                prev_reg <= meas_reg;
            end
            if (cmd.acc)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    // magnitudes for the divisions, truncation toward zero
    assign int_mag = integral_reg[ACC_W-1] ? DIV_W'(-integral_reg) : DIV_W'(integral_reg);
    assign dk_mag  = dk_reg[DK_W-1] ? DK_W'(-dk_reg) : DK_W'(dk_reg);

    // reciprocal multiply: one partial product per cycle, low halves first
    assign rq_a_hi = (rq_cnt_reg < RQ_CNT_W'(RQ_STEPS - 1));
    assign rq_b_hi = rq_cnt_reg[0];
    assign rq_a    = rq_a_hi ? RQ_HALF_W'(rq_x_reg[RQ_X_W-1:RQ_HALF_W])
                             : rq_x_reg[RQ_HALF_W-1:0];
    assign rq_b    = rq_b_hi ? RECIP_125[RQ_M_W-1:RQ_HALF_W] : RECIP_125[RQ_HALF_W-1:0];
    assign rq_pp   = rq_a * rq_b;
    assign rq_term = (RQ_ACC_W'(rq_pp) << (rq_a_hi ? RQ_HALF_W : 0))
                     << (rq_b_hi ? RQ_HALF_W : 0);

    // reciprocal step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            rq_cnt_reg <= RQ_CNT_W'(RQ_STEPS);
        end
        else if (rq_cnt_reg != '0)
        begin
            rq_cnt_reg <= rq_cnt_reg - 1'b1;
        end
    end

    // reciprocal operand and product accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rq_x_reg   <= int_mag[DIV_W-1:DIV_W-RQ_X_W];
            rq_acc_reg <= '0;
        end
        else if (rq_cnt_reg != '0)
        begin
            rq_acc_reg <= rq_acc_reg + rq_term;
        end
    end

    assign busy_rq = (rq_cnt_reg != '0);
    assign q_int   = rq_acc_reg[RQ_SHIFT +: I_W];

    pidc_div u_div_dk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_load),
        .dividend (DIV_W'(dk_mag)),
        .divisor  (dt_reg),
        .quotient (q_dk),
        .busy     (busy_dk)
    );

    assign stat.div_busy = busy_rq | busy_dk;

    // output clamp and truncation of the Q.8 sum
    assign lim     = SUM_W'({limit_reg, 8'd0});
    assign limit_s = DATA_W'({1'b0, limit_reg});
    assign over    = (s_reg > lim);
    assign under   = (s_reg < -lim);
    assign s_adj   = s_reg[SUM_W-1] ? s_reg + SUM_W'(255) : s_reg;

    // working pipeline of the step
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            meas_reg <= measurement;
            dt_reg   <= elapsed_ms;
        end
        if (cmd.mul1)
        begin
            p_reg  <= err * gain_p_reg;
            ei_reg <= err * gain_i_reg;
            dg_reg <= diff * gain_d_reg;
        end
        if (cmd.mul2)
        begin
            inc_reg <= ei_reg * $signed({1'b0, dt_reg});
            dk_reg  <= dg_reg * $signed({1'b0, MS_PER_S});
        end
        if (cmd.div_load)
        begin
            int_neg_reg <= integral_reg[ACC_W-1];
            dk_neg_reg  <= dk_reg[DK_W-1];
        end
        if (cmd.sign)
        begin
            i_reg <= int_neg_reg ? -$signed(q_int) : $signed(q_int);
            if (dt_reg == '0)
            begin
                d_reg <= '0;
            end
            else
            begin
                d_reg <= dk_neg_reg ? -$signed(q_dk[DK_W-1:0]) : $signed(q_dk[DK_W-1:0]);
            end
        end
        if (cmd.sum)
        begin
            s_reg <= SUM_W'(p_reg) + SUM_W'(i_reg) - SUM_W'(d_reg);
        end
        if (cmd.out_load)
        begin
            if (over)
            begin
                drive_reg   <= limit_s;
                clamped_reg <= 1'b1;
            end
            else if (under)
            begin
                drive_reg   <= -limit_s;
                clamped_reg <= 1'b1;
            end
            else
            begin
                drive_reg   <= s_adj[DATA_W+7:8];
                clamped_reg <= 1'b0;
            end
        end
    end

    assign drive   = drive_reg;
    assign clamped = clamped_reg;

endmodule

FILE: hdl/pidc_ctrl.sv
// Controller of the PID step: sequences the datapath and runs both
// handshakes. Uses pidc_pkg for command and status types.
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  pidc_stat_t stat,
    output pidc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_LOAD,
        ST_DIV,
        ST_SIGN,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // the output register can take a new result
    assign out_free = !out_valid_reg || !out_stall;

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.mul1     = (state_reg == ST_MUL1);
        cmd.mul2     = (state_reg == ST_MUL2);
        cmd.acc      = (state_reg == ST_ACC);
        cmd.div_load = (state_reg == ST_LOAD);
        cmd.sign     = (state_reg == ST_SIGN);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:   state_reg <= ST_MUL2;
                ST_MUL2:   state_reg <= ST_ACC;
                ST_ACC:    state_reg <= ST_LOAD;
                ST_LOAD:   state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (!stat.div_busy)
                    begin
                        state_reg <= ST_SIGN;
                    end
                end
                ST_SIGN:   state_reg <= ST_SUM;
                ST_SUM:    state_reg <= ST_FINISH;
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/pid_controller_step.sv
// PID controller step. Each request carries a measurement and the elapsed
// milliseconds; one request is worked at a time and gives one drive value
// and a clamp flag. A request is captured, multiplied twice, accumulated,
// divided, signed and summed before its result enters the output register,
// and the block can accept the next request in the cycle after that load.
// The length of a request is set by the 48-bit derivative divider
// (change term / elapsed_ms), which runs at two quotient bits per cycle.
// The integral / 1000 is a reciprocal multiply that runs beside it.
// A finished result waits in the output register while the next request
// is taken. Configuration writes are meant for idle periods only. Depends
// on pidc_pkg, pidc_ctrl, pidc_datapath and pidc_div.
module pid_controller_step
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] measurement,
    input  logic [DATA_W-1:0]        elapsed_ms,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] drive,
    output logic                     clamped
);

    pidc_cmd_t  cmd;
    pidc_stat_t stat;

    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pidc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .measurement (measurement),
        .elapsed_ms  (elapsed_ms),
        .cmd         (cmd),
        .stat        (stat),
        .drive       (drive),
        .clamped     (clamped)
    );

    // a request is never taken while the dividers are still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !stat.div_busy)
        else $error("request accepted while divider busy");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("output register overwritten");

    // after a request is taken the block is busy with it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !cmd.out_load))
        else $error("block not busy after request");

    // a new result only follows a result load
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result appeared without load");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for pid_controller_step: a directed table followed by random
// phases, with every drive result compared against the table's expected value or
// an in-bench fixed-point PID model. Depends on pidc_pkg and the pid_controller_step RTL.
module tb;
    import pidc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1100;
    localparam longint WIND_LIMIT = 64'sd1073741824;
    localparam logic [DATA_W-1:0] GAIN_TOP = 16'h7FFF;
    localparam logic [DATA_W-1:0] GAIN_BOTTOM = 16'h8000;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP = 3'd7;
    localparam logic [CFG_IDX_W-1:0] NO_REG = '0;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
    } drive_result_t;

    typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    value;
        logic [DATA_W-1:0]    span;
        logic                 known;
        drive_result_t        want;
    } plan_row_t;

    localparam drive_result_t QUIET = '{16'sd0, 1'b0};
    localparam drive_result_t HIGH_RAIL = '{16'sd32767, 1'b1};
    localparam drive_result_t LOW_RAIL = '{-16'sd32767, 1'b1};
    localparam int PLAN_LEN = 34;

    // directed table: value is the measurement of a step or the data of a write
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_STEP,  NO_REG,       16'h0000, 16'd0,     1'b1, QUIET},
        '{ROW_STEP,  NO_REG,       16'h8000, 16'd65535, 1'b1, QUIET},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd1,     1'b1, QUIET},
        '{ROW_WRITE, REG_SETPOINT, 16'd100,  16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_P,   16'h0100, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_I,   16'h0010, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_D,   16'h0008, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_LIMIT,    16'd1000, 16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'd50,   16'd10,    1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'd60,   16'd20,    1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'd60,   16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h8000, 16'd1,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd3,     1'b0, QUIET},
        '{ROW_WRITE, REG_LIMIT,    16'd0,    16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'd60,   16'd5,     1'b0, QUIET},
        '{ROW_WRITE, IDX_SPARE,    16'h1234, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, IDX_TOP,      16'hFFFF, 16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'd60,   16'd5,     1'b0, QUIET},
        '{ROW_WRITE, REG_SETPOINT, 16'h7FFF, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_P,   GAIN_TOP, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_I,   GAIN_TOP, 16'd0,     1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_D,   GAIN_BOTTOM, 16'd0,  1'b0, QUIET},
        '{ROW_WRITE, REG_LIMIT,    16'h7FFF, 16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h8000, 16'd65535, 1'b1, HIGH_RAIL},
        '{ROW_STEP,  NO_REG,       16'h8000, 16'd65535, 1'b1, HIGH_RAIL},
        '{ROW_WRITE, REG_SETPOINT, 16'h8000, 16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd65535, 1'b1, LOW_RAIL},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd65535, 1'b1, LOW_RAIL},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd65535, 1'b1, LOW_RAIL},
        '{ROW_WRITE, REG_GAIN_P,   GAIN_BOTTOM, 16'd0,  1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_I,   16'd0,    16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h7FFF, 16'd65535, 1'b0, QUIET},
        '{ROW_WRITE, REG_GAIN_D,   GAIN_TOP, 16'd0,     1'b0, QUIET},
        '{ROW_STEP,  NO_REG,       16'h8000, 16'd1,     1'b0, QUIET}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] measurement = '0;
    logic [DATA_W-1:0]        elapsed_ms = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;

    // controller model state and its copy of the registers
    logic signed [DATA_W-1:0] setpoint_m = '0;
    logic signed [DATA_W-1:0] kp_m = '0;
    logic signed [DATA_W-1:0] ki_m = '0;
    logic signed [DATA_W-1:0] kd_m = '0;
    logic [LIMIT_W-1:0]       limit_m = LIMIT_RESET;
    longint                   integ_acc = 0;
    logic signed [DATA_W-1:0] last_meas = '0;

    drive_result_t drive_due [$];
    int            mismatches = 0;
    int            idle_pct = 9;
    int            cycle_count = 0;

    pid_controller_step dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .clamped     (clamped)
    );

    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one control step of the model: updates state and returns the drive
    function automatic drive_result_t compute_drive(input logic signed [DATA_W-1:0] meas,
                                                    input logic [DATA_W-1:0] ms);
        drive_result_t r;
        longint err, diff, span, p_term, i_term, d_term, total, bound;
        span = longint'(ms);
        err = longint'(setpoint_m) - longint'(meas);
        diff = longint'(meas) - longint'(last_meas);
        p_term = err * longint'(kp_m);
        integ_acc = integ_acc + err * longint'(ki_m) * span;
        if (integ_acc > longint'(ACC_MAX))
            integ_acc = longint'(ACC_MAX);
        else if (integ_acc < longint'(ACC_MIN))
            integ_acc = longint'(ACC_MIN);
        i_term = integ_acc / longint'(MS_PER_S);
        // derivative on measurement, off when no time has passed
        d_term = 0;
        if (span != 0)
            d_term = diff * longint'(kd_m) * longint'(MS_PER_S) / span;
        total = p_term + i_term - d_term;
        bound = longint'(limit_m) * 256;
        if (total > bound)
            r = '{16'(longint'(limit_m)), 1'b1};
        else if (total < -bound)
            r = '{16'(-longint'(limit_m)), 1'b1};
        else
            r = '{16'(total / 256), 1'b0};
        last_meas = meas;
        return r;
    endfunction

    // drain: hold requests until every expected drive has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (drive_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SETPOINT: setpoint_m = val;
            REG_GAIN_P:   kp_m = val;
            REG_GAIN_I:   ki_m = val;
            REG_GAIN_D:   kd_m = val;
            REG_LIMIT:    limit_m = val[LIMIT_W-1:0];
            default:      ; // unmapped indexes leave the registers alone
        endcase
    endtask

    // one request: predict, then hold it on the port until taken
    task automatic run_step(input logic signed [DATA_W-1:0] meas, input logic [DATA_W-1:0] ms,
                            input logic known, input drive_result_t want);
        drive_result_t r;
        bit taken;
        r = compute_drive(meas, ms);
        drive_due.push_back(known ? want : r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        measurement <= meas;
        elapsed_ms <= ms;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    // bring the integrator back near zero with full integral gain
    task automatic wind_down_integral();
        longint q, e, span;
        wait_idle();
        write_reg(REG_SETPOINT, 16'd0);
        write_reg(REG_GAIN_I, GAIN_TOP);
        q = -integ_acc / 32767;
        while (q != 0)
        begin
            if (q > 32767 || q < -32767)
            begin
                e = (q > 0) ? 32767 : -32767;
                span = ((q > 0) ? q : -q) / 32767;
                if (span > 65535)
                    span = 65535;
            end
            else
            begin
                e = q;
                span = 1;
            end
            run_step(16'(-e), 16'(span), 1'b0, QUIET);
            q = -integ_acc / 32767;
        end
    endtask

    // gain or setpoint for the stress phases: a rail or anything
    function automatic logic [DATA_W-1:0] rail_or_any();
        case ($urandom_range(2))
            0: return GAIN_TOP;
            1: return GAIN_BOTTOM;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // result check, sampled on the falling edge before the accepting edge
    always @(negedge clk)
    begin : result_check
        drive_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (drive_due.size() == 0)
            begin
                $error("unexpected result: drive %0d clamped %0b", drive, clamped);
                mismatches++;
            end
            else
            begin
                want = drive_due.pop_front();
                if (drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, drive);
                    mismatches++;
                end
                if (clamped !== want.clamped)
                begin
                    $error("clamped: expected %0b, got %0b", want.clamped, clamped);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int sent;
        int phase;
        int n_items;
        bit stress;
        logic signed [DATA_W-1:0] meas;
        logic [DATA_W-1:0] ms;
        logic [LIMIT_W-1:0] lim;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(plan[k].reg_idx, plan[k].value);
            end
            else
                run_step(plan[k].value, plan[k].span, plan[k].known, plan[k].want);
        end

        // random phases, each with fresh settings
        sent = 0;
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            wait_idle();
            if (integ_acc > WIND_LIMIT || integ_acc < -WIND_LIMIT)
            begin
                wind_down_integral();
                wait_idle();
            end
            stress = (phase % 6 == 5);
            idle_pct = (phase == 2) ? 0 : 9;
            case ($urandom_range(9))
                0: lim = '0;
                1: lim = LIMIT_RESET;
                default: lim = LIMIT_W'($urandom);
            endcase
            if (stress)
            begin
                write_reg(REG_SETPOINT, rail_or_any());
                write_reg(REG_GAIN_P, rail_or_any());
                write_reg(REG_GAIN_I, rail_or_any());
                write_reg(REG_GAIN_D, rail_or_any());
            end
            else
            begin
                write_reg(REG_SETPOINT, DATA_W'($urandom));
                write_reg(REG_GAIN_P, DATA_W'(int'($urandom_range(4096)) - 2048));
                write_reg(REG_GAIN_I, DATA_W'(int'($urandom_range(1024)) - 512));
                write_reg(REG_GAIN_D, DATA_W'(int'($urandom_range(128)) - 64));
            end
            write_reg(REG_LIMIT, {1'($urandom), lim});
            if ($urandom_range(3) == 0)
                write_reg(IDX_SPARE + CFG_IDX_W'($urandom_range(2)), DATA_W'($urandom));

            n_items = $urandom_range(30, 80);
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(49) == 0)
                    wait_idle();
                if (stress || $urandom_range(99) < 15)
                begin
                    meas = DATA_W'($urandom);
                    ms = DATA_W'($urandom);
                end
                else
                begin
                    // tracking near the setpoint
                    meas = DATA_W'(int'(setpoint_m) + int'($urandom_range(600)) - 300);
                    ms = ($urandom_range(9) == 0) ? '0 : DATA_W'($urandom_range(1, 500));
                end
                run_step(meas, ms, 1'b0, QUIET);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && drive_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
